### rtl/sli_pkg.sv
package sli_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned MAX_OUT = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } sli_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry;
    logic [4:0]         count;
    logic               last;
  } sli_rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK_INS,
    CELL_MARK_DEL,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } sli_cell_op_t;

  typedef struct packed {
    sli_cell_op_t       op;
    logic signed [31:0] value;
    logic               found;
  } sli_cell_ctl_t;

endpackage

### rtl/sli_stream_if.sv
interface sli_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/sli_cell.sv
module sli_cell import sli_pkg::*; (
  input  logic               clk,
  input  sli_cell_ctl_t      ctl,
  input  logic               live,
  input  logic               tail,
  input  logic               left_mark,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  input  logic signed [31:0] head_entry,
  output logic signed [31:0] entry,
  output logic               mark,
  output logic               hit
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_MARK_INS: begin
        mark <= !live || (entry > ctl.value);
        hit  <= live && (entry == ctl.value);
      end
      CELL_MARK_DEL: begin
        mark <= live && (entry >= ctl.value);
        hit  <= live && (entry == ctl.value);
      end
      CELL_INSERT: begin
        if (mark) begin
          entry <= left_mark ? left_entry : ctl.value;
        end
      end
      CELL_DELETE: begin
        if (ctl.found && mark) begin
          entry <= right_entry;
        end
      end
      CELL_ROTATE: begin
        if (live) begin
          entry <= tail ? head_entry : right_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/sorted_list_insert_delete.sv
// Sorted store of signed 32-bit values held in a row of CAPACITY cells, one entry per
// cell, kept in ascending order. Every cell compares its entry with the request value
// in the beat's accept cycle, and once the output register is free the marked cells
// shift together, so insert and delete each return one result. A dump rotates the held
// entries through the first cell one per cycle while the output register is free, and
// gives one result beat per entry, at most sixteen, the final one marked last; an
// empty dump gives one empty-status beat. Entries need no clearing after reset. A
// result waits in an output register, and a new request is taken while it waits.
module sorted_list_insert_delete import sli_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input logic clk,
  input logic rst,
  sli_stream_if.sink   req,
  sli_stream_if.source rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_APPLY = 3'b010,
    S_DUMP  = 3'b100
  } state_t;

  state_t             state;
  logic [1:0]         op;
  logic signed [31:0] value;
  logic [CW-1:0]      held;
  logic [CW-1:0]      k;
  logic               out_valid;
  sli_rsp_t           out_data;

  sli_cell_ctl_t      ctl;
  logic signed [31:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_mark;
  logic [CAPACITY-1:0] cell_hit;
  logic               found;
  logic               out_free;
  logic               out_load;
  logic               req_take;
  logic [31:0]        dump_n;

  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign found     = |cell_hit;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign dump_n    = (32'(held) < MAX_OUT) ? 32'(held) : MAX_OUT;
  assign out_load  = out_free &&
                     ((state == S_APPLY && (op != CMD_DUMP || held == '0)) ||
                      (state == S_DUMP && 32'(k) < MAX_OUT));

  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = value;
    ctl.found = found;
    case (state)
      S_IDLE: begin
        ctl.value = req.data.value;
        if (req_take && req.data.cmd == CMD_INSERT) begin
          ctl.op = CELL_MARK_INS;
        end else if (req_take && req.data.cmd == CMD_DELETE) begin
          ctl.op = CELL_MARK_DEL;
        end
      end
      S_APPLY: begin
        if (out_free && op == CMD_INSERT && 32'(held) < CAPACITY) begin
          ctl.op = CELL_INSERT;
        end else if (out_free && op == CMD_DELETE && held != '0) begin
          ctl.op = CELL_DELETE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl.op = CELL_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               live;
    logic               tail;
    logic               left_mark;
    logic signed [31:0] left_entry;
    logic signed [31:0] right_entry;

    assign live = (CW'(i) < held);
    assign tail = (CW'(i + 1) == held);
    if (i == 0) begin : g_first
      assign left_mark  = 1'b0;
      assign left_entry = cell_entry[i];
    end else begin : g_inner
      assign left_mark  = cell_mark[i-1];
      assign left_entry = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    sli_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .live        (live),
      .tail        (tail),
      .left_mark   (left_mark),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .head_entry  (cell_entry[0]),
      .entry       (cell_entry[i]),
      .mark        (cell_mark[i]),
      .hit         (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_take && req.data.cmd != CMD_UNUSED) begin
            op    <= req.data.cmd;
            value <= req.data.value;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            out_data.entry <= '0;
            out_data.last  <= 1'b1;
            case (op)
              CMD_INSERT: begin
                state <= S_IDLE;
                if (32'(held) < CAPACITY) begin
                  held            <= held + CW'(1);
                  out_data.count  <= 5'(held + CW'(1));
                  out_data.status <= ST_OK;
                end else begin
                  out_data.count  <= 5'(held);
                  out_data.status <= ST_FULL;
                end
              end
              CMD_DELETE: begin
                state <= S_IDLE;
                if (held == '0) begin
                  out_data.count  <= 5'(held);
                  out_data.status <= ST_EMPTY;
                end else if (!found) begin
                  out_data.count  <= 5'(held);
                  out_data.status <= ST_NOT_FOUND;
                end else begin
                  held            <= held - CW'(1);
                  out_data.count  <= 5'(held - CW'(1));
                  out_data.status <= ST_OK;
                end
              end
              default: begin
                out_data.count <= 5'(held);
                if (held == '0) begin
                  out_data.status <= ST_EMPTY;
                  state           <= S_IDLE;
                end else begin
                  k     <= '0;
                  state <= S_DUMP;
                end
              end
            endcase
          end
        end
        S_DUMP: begin
          if (out_free) begin
            if (32'(k) < MAX_OUT) begin
              out_data.status <= ST_OK;
              out_data.entry  <= cell_entry[0];
              out_data.count  <= 5'(held);
              out_data.last   <= (32'(k) + 32'd1 == dump_n);
            end
            k <= k + CW'(1);
            if (k + CW'(1) == held) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= CAPACITY)
    else $error("held count exceeds capacity");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> held != '0)
    else $error("dump running on an empty list");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && out_free && op == CMD_INSERT && 32'(held) < CAPACITY)
    |=> held == $past(held) + CW'(1))
    else $error("insert did not grow the list");

  a_dump_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP && out_free && k + CW'(1) == held) |=> state == S_IDLE)
    else $error("dump did not finish after the last entry");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
module tb;
  import sli_pkg::*;

  localparam int unsigned CAP          = DEFAULT_CAPACITY;
  localparam int unsigned NUM_ITEMS    = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  class list_scoreboard;
    logic signed [31:0] sorted_vals[$];
    sli_rsp_t           expected_rsps[$];
    int mismatches = 0;
    int unexpected = 0;
    int beats      = 0;
    int n_insert   = 0;
    int n_full     = 0;
    int n_delete   = 0;
    int n_missing  = 0;
    int n_dump     = 0;

    function void push_rsp(logic [1:0] status, logic signed [31:0] entry, logic last);
      sli_rsp_t r;
      r.status = status;
      r.entry  = entry;
      r.count  = 5'(sorted_vals.size());
      r.last   = last;
      expected_rsps.push_back(r);
    endfunction

    function void note_request(sli_req_t req);
      logic signed [31:0] v;
      int pos;
      int n;
      int i;
      v = req.value;
      case (req.cmd)
        CMD_INSERT: begin
          n_insert++;
          if (sorted_vals.size() >= CAP) begin
            n_full++;
            push_rsp(ST_FULL, 0, 1'b1);
          end else begin
            pos = 0;
            while (pos < sorted_vals.size() && sorted_vals[pos] <= v) pos++;
            sorted_vals.insert(pos, v);
            push_rsp(ST_OK, 0, 1'b1);
          end
        end
        CMD_DELETE: begin
          n_delete++;
          if (sorted_vals.size() == 0) begin
            push_rsp(ST_EMPTY, 0, 1'b1);
          end else begin
            pos = 0;
            while (pos < sorted_vals.size() && sorted_vals[pos] != v) pos++;
            if (pos == sorted_vals.size()) begin
              n_missing++;
              push_rsp(ST_NOT_FOUND, 0, 1'b1);
            end else begin
              sorted_vals.delete(pos);
              push_rsp(ST_OK, 0, 1'b1);
            end
          end
        end
        CMD_DUMP: begin
          n_dump++;
          if (sorted_vals.size() == 0) begin
            push_rsp(ST_EMPTY, 0, 1'b1);
          end else begin
            n = (sorted_vals.size() < MAX_OUT) ? sorted_vals.size() : MAX_OUT;
            for (i = 0; i < n; i++) push_rsp(ST_OK, sorted_vals[i], i == n - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(sli_rsp_t got);
      sli_rsp_t want;
      beats++;
      if (expected_rsps.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= REPORT_LIMIT)
          $display("ERROR: unexpected beat status=%0d entry=%0d count=%0d last=%0d",
                   got.status, got.entry, got.count, got.last);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status || got.entry !== want.entry ||
          got.count !== want.count || got.last !== want.last) begin
        mismatches++;
        if (mismatches + unexpected <= REPORT_LIMIT)
          $display({"ERROR: beat %0d expected status=%0d entry=%0d count=%0d last=%0d,",
                    " got status=%0d entry=%0d count=%0d last=%0d"},
                   beats, want.status, want.entry, want.count, want.last,
                   got.status, got.entry, got.count, got.last);
      end
    endfunction

    function int held_count();
      return sorted_vals.size();
    endfunction

    function logic signed [31:0] held_value();
      return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    function int failures();
      return mismatches + unexpected + expected_rsps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  list_scoreboard sb;
  bit idle_on;
  bit long_hold_req;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  sli_stream_if #(.payload_t(sli_req_t)) req_if ();
  sli_stream_if #(.payload_t(sli_rsp_t)) rsp_if ();

  sorted_list_insert_delete #(.CAPACITY(CAP)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst == 1'b0 && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = idle_on ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 11);
    if (r < 6) return int'($urandom_range(0, 16)) - 8;
    else if (r < 9) return $urandom();
    else if (r == 9) return VAL_MIN;
    else if (r == 10) return VAL_MAX;
    else return -1;
  endfunction

  function automatic logic signed [31:0] delete_value();
    if (sb.held_count() > 0 && $urandom_range(0, 9) < 7) return sb.held_value();
    return rand_value();
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] value);
    int gap;
    sli_req_t req;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    req.cmd = cmd;
    req.value = value;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= req;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(req);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic fill_list();
    int extra;
    extra = $urandom_range(1, 2);
    while (sb.held_count() < CAP) send_item(CMD_INSERT, rand_value());
    repeat (extra) send_item(CMD_INSERT, rand_value());
    send_item(CMD_DUMP, $urandom());
  endtask

  task automatic drain_list();
    while (sb.held_count() > 0)
      send_item(CMD_DELETE, ($urandom_range(0, 4) == 0) ? rand_value() : sb.held_value());
    send_item(CMD_DELETE, rand_value());
    send_item(CMD_DUMP, $urandom());
  endtask

  task automatic mixed_ops(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) send_item(CMD_INSERT, rand_value());
      else if (pick < 16) send_item(CMD_DELETE, delete_value());
      else if (pick < 19) send_item(CMD_DUMP, $urandom());
      else send_item(CMD_UNUSED, $urandom());
    end
  endtask

  initial begin
    int seq;
    sb = new();
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_DUMP, 32'sh5a5a_5a5a);
    send_item(CMD_DELETE, 0);
    send_item(CMD_UNUSED, 32'sh1234_5678);
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 1);
    send_item(CMD_DUMP, -1);
    send_item(CMD_DELETE, 5);
    send_item(CMD_DELETE, 0);
    send_item(CMD_DELETE, VAL_MIN);
    send_item(CMD_DELETE, VAL_MAX);
    send_item(CMD_UNUSED, VAL_MIN);
    send_item(CMD_DUMP, VAL_MAX);
    send_item(CMD_DELETE, -1);
    send_item(CMD_DELETE, 0);
    send_item(CMD_DELETE, 1);
    send_item(CMD_DUMP, 0);
    wait_idle();

    fill_list();
    // The sink stalls for a long stretch while beats keep arriving back to back.
    idle_on = 1'b0;
    long_hold_req = 1'b1;
    mixed_ops(40);
    wait_idle();

    while (items_sent < NUM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      seq = $urandom_range(0, 5);
      if (seq == 0) fill_list();
      else if (seq == 1) drain_list();
      else mixed_ops($urandom_range(4, 16));
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
    wait_idle();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d inserts (%0d refused as full), %0d deletes (%0d misses),",
             sb.n_insert, sb.n_full, sb.n_delete, sb.n_missing);
    $display("%0d dumps and %0d result beats; errors: %0d mismatched, %0d unexpected, %0d outstanding.",
             sb.n_dump, sb.beats, sb.mismatches, sb.unexpected, sb.pending());
    if (sb.failures() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
